// ===== src/bbf_pkg.sv =====
// Shared types and constants for the bounding box fit block.
`default_nettype none
package bbf_pkg;

	// Point format: signed fixed point, COORD_BITS wide, FRAC_BITS fraction bits
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 8;

	// Window size registers and the Q16.16 scale
	localparam int SIZE_W     = 14;
	localparam int SCALE_W    = 32;
	localparam int SCALE_FRAC = 16;

	// Window size shifted up to the ratio's fraction position
	localparam int FULL_W = SIZE_W + SCALE_FRAC + FRAC_BITS;

	// Signed product of a coordinate and the scale, and the offset sum
	localparam int PROD_W = COORD_BITS + SCALE_W + 2;
	localparam int ACC_W  = PROD_W + 1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});

	// Running extent of the current frame
	typedef struct packed {
		coord_t min_x;
		coord_t max_x;
		coord_t min_y;
		coord_t max_y;
	} box_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic done;
		logic over;
	} div_stat_t;

endpackage
`default_nettype wire

// ===== src/bbf_box.sv =====
// Running minimum and maximum of the point stream.
`default_nettype none
module bbf_box (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           upd,
	input  wire logic           clr,
	input  wire bbf_pkg::coord_t point_x,
	input  wire bbf_pkg::coord_t point_y,
	output bbf_pkg::box_t       box
);

	bbf_pkg::box_t box_q;

	// Fold a transferred point into the box, or clear it after a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q.min_x <= bbf_pkg::COORD_MAX;
			box_q.min_y <= bbf_pkg::COORD_MAX;
			box_q.max_x <= bbf_pkg::COORD_MIN;
			box_q.max_y <= bbf_pkg::COORD_MIN;
		end else if (clr) begin
			box_q.min_x <= bbf_pkg::COORD_MAX;
			box_q.min_y <= bbf_pkg::COORD_MAX;
			box_q.max_x <= bbf_pkg::COORD_MIN;
			box_q.max_y <= bbf_pkg::COORD_MIN;
		end else if (upd) begin
			if (point_x < box_q.min_x) box_q.min_x <= point_x;
			if (point_x > box_q.max_x) box_q.max_x <= point_x;
			if (point_y < box_q.min_y) box_q.min_y <= point_y;
			if (point_y > box_q.max_y) box_q.max_y <= point_y;
		end
	end

	assign box = box_q;

endmodule
`default_nettype wire

// ===== src/bbf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the fit ratios.
`default_nettype none
module bbf_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [bbf_pkg::FULL_W-1:0]          dividend,
	input  wire logic [bbf_pkg::COORD_BITS-1:0]      divisor,
	output logic      [bbf_pkg::SCALE_W-1:0]         quot,
	output bbf_pkg::div_stat_t                       stat
);

	localparam int DVD_W = bbf_pkg::FULL_W;
	localparam int DVS_W = bbf_pkg::COORD_BITS;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] dvd_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_dif;
	logic             ge;
	logic [DVS_W-1:0] rem_nx;

	// One trial subtract per step; a zero divisor yields all ones
	always_comb begin
		rem_sh  = {rem_q, dvd_q[DVD_W-1]};
		rem_dif = rem_sh - {1'b0, dvs_q};
		ge      = (rem_sh >= {1'b0, dvs_q});
		rem_nx  = ge ? rem_dif[DVS_W-1:0] : rem_sh[DVS_W-1:0];
	end

	// Step counter and completion strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then shift quotient bits in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign quot      = dvd_q[bbf_pkg::SCALE_W-1:0];
	assign stat.done = done_q;
	assign stat.over = |dvd_q[DVD_W-1:bbf_pkg::SCALE_W];

endmodule
`default_nettype wire

// ===== src/bounding_box_fit_to_window.sv =====
// Top level: box tracking, fit sequencer, shared multiplier and offset adder.
//
// Channel   Direction  Signals                                       Transfer
// input     in         start, busy, point_x, point_y, last_point     start && !busy
// result    out        done, scale_factor, shift_x, shift_y, degen.  done (one cycle)
// config    in         cfg_write, cfg_index, cfg_data                cfg_write
//
// A point without last_point is folded into the box on transfer; points may follow back to back.
// A last point holds busy high while the spans are captured, two 38-step
// ratio divisions run on the shared divider, the scale is picked, and then
// six multiply and add steps run.
// done pulses in the first cycle with busy low; the receiver cannot stall it.
// Reset restores an empty box and a 1920 by 1080 window.
`default_nettype none
module bounding_box_fit_to_window (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire bbf_pkg::coord_t                       point_x,
	input  wire bbf_pkg::coord_t                       point_y,
	input  wire logic                                  last_point,
	output logic                                       done,
	output logic [bbf_pkg::SCALE_W-1:0]                scale_factor,
	output bbf_pkg::coord_t                            shift_x,
	output bbf_pkg::coord_t                            shift_y,
	output logic                                       degenerate,
	input  wire logic                                  cfg_write,
	input  wire logic [bbf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [bbf_pkg::SIZE_W-1:0]            cfg_data
);

	localparam int CB     = bbf_pkg::COORD_BITS;
	localparam int SW     = bbf_pkg::SCALE_W;
	localparam int FW     = bbf_pkg::FULL_W;
	localparam int PW     = bbf_pkg::PROD_W;
	localparam int AW     = bbf_pkg::ACC_W;
	localparam int SHR_W  = AW - bbf_pkg::SCALE_FRAC;
	localparam int LOW0_W = bbf_pkg::SCALE_FRAC + bbf_pkg::FRAC_BITS;

	// Sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SPAN   = 3'd1;
	localparam logic [2:0] S_DSTART = 3'd2;
	localparam logic [2:0] S_DWAIT  = 3'd3;
	localparam logic [2:0] S_SCALE  = 3'd4;
	localparam logic [2:0] S_MSPAN  = 3'd5;
	localparam logic [2:0] S_MLO    = 3'd6;
	localparam logic [2:0] S_SUM    = 3'd7;

	logic [2:0]                 state_q;
	logic                       axis_q;
	logic                       done_q;
	logic [bbf_pkg::SIZE_W-1:0] width_q;
	logic [bbf_pkg::SIZE_W-1:0] height_q;

	logic [CB-1:0]              span_x_q;
	logic [CB-1:0]              span_y_q;
	bbf_pkg::coord_t            lo_x_q;
	bbf_pkg::coord_t            lo_y_q;
	logic                       degen_q;
	logic [SW-1:0]              ratio_x_q;
	logic [SW-1:0]              ratio_y_q;
	logic [SW-1:0]              scale_q;
	logic signed [PW-1:0]       prod_q;
	logic [FW-2:0]              c_q;
	bbf_pkg::coord_t            shx_q;
	bbf_pkg::coord_t            shy_q;

	logic                       accept;
	bbf_pkg::box_t              box;
	logic                       div_start;
	logic [SW-1:0]              div_quot;
	bbf_pkg::div_stat_t         div_st;
	logic [SW-1:0]              ratio;

	logic [bbf_pkg::SIZE_W-1:0] size_sel;
	logic [FW-1:0]              full_sel;
	logic [CB-1:0]              span_sel;
	bbf_pkg::coord_t            lo_sel;
	logic signed [CB:0]         mul_a;
	logic signed [SW:0]         mul_b;
	logic signed [PW-1:0]       mul_p;
	logic [FW-1:0]              diff;
	logic signed [AW-1:0]       acc;
	logic [SHR_W-1:0]           shr;
	logic [SHR_W-CB:0]          shr_top;
	bbf_pkg::coord_t            shift_sat;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Window size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbf_pkg::WIDTH_RST;
			height_q <= bbf_pkg::HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bbf_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				bbf_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bbf_box u_box (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (accept),
		.clr     (state_q == S_SPAN),
		.point_x (point_x),
		.point_y (point_y),
		.box     (box)
	);

	// Per-axis operand selection
	always_comb begin
		size_sel = axis_q ? height_q : width_q;
		full_sel = {size_sel, {LOW0_W{1'b0}}};
		span_sel = axis_q ? span_y_q : span_x_q;
		lo_sel   = axis_q ? lo_y_q : lo_x_q;
	end

	assign div_start = (state_q == S_DSTART);

	bbf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (full_sel),
		.divisor  (span_sel),
		.quot     (div_quot),
		.stat     (div_st)
	);

	// Saturate the quotient to the scale width
	assign ratio = div_st.over ? {SW{1'b1}} : div_quot;

	// Shared signed multiplier: span or box minimum times the scale
	always_comb begin
		mul_a = (state_q == S_MSPAN) ? $signed({1'b0, span_sel}) : $signed({lo_sel[CB-1], lo_sel});
		mul_b = $signed({1'b0, scale_q});
		mul_p = PW'(mul_a) * PW'(mul_b);
	end

	// Halved leftover and offset sum, rounded toward minus infinity
	always_comb begin
		diff      = full_sel - prod_q[FW-1:0];
		acc       = $signed({{(AW-FW+1){1'b0}}, c_q}) - AW'(prod_q);
		shr       = acc[AW-1:bbf_pkg::SCALE_FRAC];
		shr_top   = shr[SHR_W-1:CB-1];
		if ((&shr_top) || !(|shr_top)) begin
			shift_sat = bbf_pkg::coord_t'(shr[CB-1:0]);
		end else if (shr[SHR_W-1]) begin
			shift_sat = bbf_pkg::COORD_MIN;
		end else begin
			shift_sat = bbf_pkg::COORD_MAX;
		end
	end

	// Fit sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					axis_q <= 1'b0;
					if (accept && last_point) state_q <= S_SPAN;
				end
				S_SPAN:   state_q <= S_DSTART;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_st.done) begin
						axis_q  <= !axis_q;
						state_q <= axis_q ? S_SCALE : S_DSTART;
					end
				end
				S_SCALE: state_q <= S_MSPAN;
				S_MSPAN: state_q <= S_MLO;
				S_MLO:   state_q <= S_SUM;
				S_SUM: begin
					axis_q <= !axis_q;
					if (axis_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MSPAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_SPAN) begin
			span_x_q <= CB'(box.max_x - box.min_x);
			span_y_q <= CB'(box.max_y - box.min_y);
			lo_x_q   <= box.min_x;
			lo_y_q   <= box.min_y;
			degen_q  <= (box.max_x == box.min_x) && (box.max_y == box.min_y);
		end
		if (state_q == S_DWAIT && div_st.done) begin
			if (axis_q) ratio_y_q <= ratio;
			else        ratio_x_q <= ratio;
		end
		if (state_q == S_SCALE) begin
			scale_q <= (ratio_x_q < ratio_y_q) ? ratio_x_q : ratio_y_q;
		end
		if (state_q == S_MSPAN || state_q == S_MLO) begin
			prod_q <= mul_p;
		end
		if (state_q == S_MLO) begin
			c_q <= diff[FW-1:1];
		end
		if (state_q == S_SUM) begin
			if (axis_q) shy_q <= shift_sat;
			else        shx_q <= shift_sat;
		end
	end

	assign done         = done_q;
	assign scale_factor = scale_q;
	assign shift_x      = shx_q;
	assign shift_y      = shy_q;
	assign degenerate   = degen_q;

	// A result only follows the last offset step
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_SUM) && $past(axis_q))
		else $error("result strobe without a finished offset step");

	// The sequencer only leaves idle on a transferred last point
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) ##1 (state_q != S_IDLE) |-> $past(accept && last_point))
		else $error("sequencer started without a last point");

	// Divider completion is only seen while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == S_DWAIT))
		else $error("divider finished outside the wait state");

	// A degenerate frame always carries a saturated scale
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && degen_q) |-> (scale_q == {SW{1'b1}}))
		else $error("degenerate result without saturated scale");

endmodule
`default_nettype wire
